### rtl/ecc_pad_pkg.sv
package ecc_pad_pkg;

	localparam int WORD_W = 64;
	localparam int COORD_WORDS = 4;
	localparam int FE_W = WORD_W * COORD_WORDS;

	localparam logic [FE_W-1:0] PRIME =
		256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFEFFFFFC2F;
	localparam logic [FE_W-1:0] PRIME_M2 =
		256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFEFFFFFC2D;

	typedef enum logic [1:0] {
		REQ_LOAD = 2'd0,
		REQ_ADD  = 2'd1,
		REQ_DBL  = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_RD,
		ST_EX,
		ST_WB,
		ST_INIT,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_PRE,
		PH_INV,
		PH_POST
	} phase_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL
	} opc_t;

	typedef logic [3:0] reg_idx_t;

	localparam reg_idx_t R_X1  = 4'd0;
	localparam reg_idx_t R_Y1  = 4'd1;
	localparam reg_idx_t R_X2  = 4'd2;
	localparam reg_idx_t R_Y2  = 4'd3;
	localparam reg_idx_t R_NUM = 4'd4;
	localparam reg_idx_t R_DEN = 4'd5;
	localparam reg_idx_t R_S   = 4'd6;
	localparam reg_idx_t R_T   = 4'd7;
	localparam reg_idx_t R_RX  = 4'd8;
	localparam reg_idx_t R_RY  = 4'd9;
	localparam reg_idx_t R_ACC = 4'd10;

	typedef struct packed {
		opc_t     opc;
		reg_idx_t rd;
		reg_idx_t ra;
		reg_idx_t rb;
	} op_t;

	function automatic logic [FE_W-1:0] mod_add(input logic [FE_W-1:0] a,
			input logic [FE_W-1:0] b);
		logic [FE_W:0] s;
		logic [FE_W:0] d;
		s = {1'b0, a} + {1'b0, b};
		d = s - {1'b0, PRIME};
		mod_add = d[FE_W] ? s[FE_W-1:0] : d[FE_W-1:0];
	endfunction

	function automatic logic [FE_W-1:0] mod_sub(input logic [FE_W-1:0] a,
			input logic [FE_W-1:0] b);
		logic [FE_W:0] d;
		d = {1'b0, a} - {1'b0, b};
		mod_sub = d[FE_W] ? (d[FE_W-1:0] + PRIME) : d[FE_W-1:0];
	endfunction

	function automatic op_t pre_op(input logic dbl, input logic [2:0] pc);
		op_t o;
		o = '{OP_ADD, R_NUM, R_T, R_T};
		if (!dbl) begin
			case (pc)
				3'd0: o = '{OP_SUB, R_NUM, R_Y1, R_Y2};
				default: o = '{OP_SUB, R_DEN, R_X1, R_X2};
			endcase
		end else begin
			case (pc)
				3'd0: o = '{OP_MUL, R_T, R_X1, R_X1};
				3'd1: o = '{OP_ADD, R_NUM, R_T, R_T};
				3'd2: o = '{OP_ADD, R_NUM, R_NUM, R_T};
				default: o = '{OP_ADD, R_DEN, R_Y1, R_Y1};
			endcase
		end
		pre_op = o;
	endfunction

	function automatic op_t post_op(input logic dbl, input logic [2:0] pc);
		op_t o;
		case (pc)
			3'd0: o = '{OP_MUL, R_S, R_NUM, R_ACC};
			3'd1: o = '{OP_MUL, R_RX, R_S, R_S};
			3'd2: o = '{OP_SUB, R_RX, R_RX, R_X1};
			3'd3: o = '{OP_SUB, R_RX, R_RX, dbl ? R_X1 : R_X2};
			3'd4: o = '{OP_SUB, R_T, R_X1, R_RX};
			3'd5: o = '{OP_MUL, R_T, R_S, R_T};
			default: o = '{OP_SUB, R_RY, R_T, R_Y1};
		endcase
		post_op = o;
	endfunction

endpackage

### rtl/ecc_point_add_double_unit.sv
// a run transaction is followed by eight result transactions; operand loads are
// accepted only while the unit is idle
// one run at a time; the run time is set by the bit-serial modular multiplier (256 bits
// per multiplication) used 505 times for the inversion by exponentiation
// reset: arst_n clears the control state only; operand and result words stay undefined
module ecc_point_add_double_unit import ecc_pad_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // word_value
	input  logic [7:0]  s_tuser,   // req_type, operand_sel, word_index, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // result_word
	output logic [7:0]  m_tuser,   // coord_sel, result_index, no_inverse, zero pad
	output logic        m_tlast
);

	state_t state_q, state_d;
	phase_t phase_q;
	logic [2:0] pc_q;
	logic [7:0] bit_q;
	logic sq_q;
	logic [7:0] mcnt_q;
	logic half_q;
	logic dbl_q;
	logic err_q;
	logic [1:0] rcnt_q;
	logic [2:0] k_q;

	logic [WORD_W-1:0] opnd_q [16];
	logic [FE_W-1:0] rf_mem [16];
	logic [FE_W-1:0] rda_q, rdb_q;
	logic [FE_W-1:0] res_q;
	logic [FE_W-1:0] rx_q, ry_q;

	op_t op;
	logic pre_last;
	logic inv_done;
	logic rf_we;
	reg_idx_t rf_wa;
	logic [FE_W-1:0] rf_wd;
	logic [FE_W-1:0] red_in;
	logic [FE_W-1:0] alu_out;
	logic in_hs, out_hs;
	req_t req;

	assign req = req_t'(s_tuser[1:0]);
	assign in_hs = s_tvalid && s_tready;
	assign out_hs = m_tvalid && m_tready;
	assign pre_last = dbl_q ? (pc_q == 3'd3) : (pc_q == 3'd1);
	assign inv_done = (bit_q == 8'd0) && (!sq_q || !PRIME_M2[bit_q]);

	always_comb begin
		case (phase_q)
			PH_PRE:  op = pre_op(dbl_q, pc_q);
			PH_INV:  op = '{OP_MUL, R_ACC, R_ACC, sq_q ? R_ACC : R_DEN};
			default: op = post_op(dbl_q, pc_q);
		endcase
	end

	always_comb begin
		case (op.opc)
			OP_ADD:  alu_out = mod_add(rda_q, rdb_q);
			OP_SUB:  alu_out = mod_sub(rda_q, rdb_q);
			default: alu_out = half_q ? mod_add(res_q, rdb_q) : mod_add(res_q, res_q);
		endcase
	end

	assign red_in = {opnd_q[{rcnt_q, 2'd3}], opnd_q[{rcnt_q, 2'd2}],
		opnd_q[{rcnt_q, 2'd1}], opnd_q[{rcnt_q, 2'd0}]};

	always_comb begin
		state_d = state_q;
		rf_we = 1'b0;
		rf_wa = op.rd;
		rf_wd = res_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && (req == REQ_ADD || req == REQ_DBL))
					state_d = ST_REDUCE;
			end
			ST_REDUCE: begin
				rf_we = 1'b1;
				rf_wa = {2'd0, rcnt_q};
				rf_wd = mod_add(red_in, '0);
				if (rcnt_q == 2'd3)
					state_d = ST_RD;
			end
			ST_RD: state_d = ST_EX;
			ST_EX: begin
				if (op.opc != OP_MUL || (half_q && mcnt_q == 8'd0))
					state_d = ST_WB;
			end
			ST_WB: begin
				rf_we = 1'b1;
				case (phase_q)
					PH_PRE: begin
						if (pre_last)
							state_d = (res_q == '0) ? ST_OUT : ST_INIT;
						else
							state_d = ST_RD;
					end
					PH_INV: state_d = ST_RD;
					default: state_d = (pc_q == 3'd6) ? ST_OUT : ST_RD;
				endcase
			end
			ST_INIT: begin
				rf_we = 1'b1;
				rf_wa = R_ACC;
				rf_wd = {{(FE_W-1){1'b0}}, 1'b1};
				state_d = ST_RD;
			end
			ST_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready && k_q == 3'd7)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_PRE;
			pc_q <= '0;
			bit_q <= '0;
			sq_q <= 1'b1;
			mcnt_q <= '0;
			half_q <= 1'b0;
			dbl_q <= 1'b0;
			err_q <= 1'b0;
			rcnt_q <= '0;
			k_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (in_hs) begin
						dbl_q <= (req == REQ_DBL);
						rcnt_q <= '0;
						phase_q <= PH_PRE;
						pc_q <= '0;
						k_q <= '0;
					end
				end
				ST_REDUCE: rcnt_q <= rcnt_q + 2'd1;
				ST_RD: begin
					mcnt_q <= 8'd255;
					half_q <= 1'b0;
				end
				ST_EX: begin
					if (op.opc == OP_MUL) begin
						half_q <= !half_q;
						if (half_q)
							mcnt_q <= mcnt_q - 8'd1;
					end
				end
				ST_WB: begin
					case (phase_q)
						PH_PRE: begin
							if (pre_last) begin
								err_q <= (res_q == '0);
								phase_q <= PH_INV;
								bit_q <= 8'd255;
								sq_q <= 1'b1;
							end else
								pc_q <= pc_q + 3'd1;
						end
						PH_INV: begin
							if (inv_done) begin
								phase_q <= PH_POST;
								pc_q <= '0;
							end else if (sq_q && PRIME_M2[bit_q])
								sq_q <= 1'b0;
							else begin
								sq_q <= 1'b1;
								bit_q <= bit_q - 8'd1;
							end
						end
						default: pc_q <= pc_q + 3'd1;
					endcase
				end
				ST_OUT: begin
					if (out_hs)
						k_q <= k_q + 3'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_hs && req == REQ_LOAD)
			opnd_q[{s_tuser[3:2], s_tuser[5:4]}] <= s_tdata;
		if (rf_we)
			rf_mem[rf_wa] <= rf_wd;
		rda_q <= rf_mem[op.ra];
		rdb_q <= rf_mem[op.rb];
		if (state_q == ST_RD)
			res_q <= '0;
		else if (state_q == ST_EX) begin
			if (op.opc != OP_MUL || !half_q || rda_q[mcnt_q])
				res_q <= alu_out;
		end
		if (state_q == ST_WB) begin
			if (phase_q == PH_PRE && pre_last && res_q == '0) begin
				rx_q <= '0;
				ry_q <= '0;
			end
			if (op.rd == R_RX)
				rx_q <= res_q;
			if (op.rd == R_RY)
				ry_q <= res_q;
		end
	end

	assign m_tdata = k_q[2] ? ry_q[k_q[1:0]*WORD_W +: WORD_W] : rx_q[k_q[1:0]*WORD_W +: WORD_W];
	assign m_tuser = {4'd0, err_q, k_q[1:0], k_q[2]};
	assign m_tlast = (k_q == 3'd7);

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
	import ecc_pad_pkg::*;

	typedef struct {
		req_t        req;
		logic [1:0]  sel;
		logic [1:0]  idx;
		logic [63:0] val;
		logic        err_known;
	} point_req_t;

	typedef struct {
		logic        coord;
		logic [1:0]  idx;
		logic [63:0] word;
		logic        noinv;
		logic        last;
	} word_exp_t;

	localparam logic [255:0] GX =
		256'h79BE667EF9DCBBAC55A06295CE870B07029BFCDB2DCE28D959F2815B16F81798;
	localparam logic [255:0] GY =
		256'h483ADA7726A3C4655DA4FBFC0E1108A8FD17B448A68554199C47D08FFB10D4B8;
	localparam int IDLE_LIMIT = 800000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [7:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic [7:0]  m_tuser;
	logic        m_tlast;

	point_req_t  stim_q[$];
	word_exp_t   result_q[$];
	logic [63:0] operand_words[16];
	int          errors;
	int          runs_done;
	int          loads_done;
	int          words_checked;
	int          idle_cycles;
	logic        stim_done;
	logic        held_once;
	int          hold_left;
	logic        stall_on;

	ecc_point_add_double_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [255:0] fe_add(logic [255:0] a, logic [255:0] b);
		logic [256:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, PRIME})
			s = s - {1'b0, PRIME};
		return s[255:0];
	endfunction

	function automatic logic [255:0] fe_sub(logic [255:0] a, logic [255:0] b);
		if (a >= b)
			return a - b;
		return PRIME - (b - a);
	endfunction

	function automatic logic [255:0] fe_mul(logic [255:0] a, logic [255:0] b);
		logic [511:0] pr;
		logic [511:0] rm;
		pr = {256'b0, a} * {256'b0, b};
		rm = pr % {256'b0, PRIME};
		return rm[255:0];
	endfunction

	function automatic logic [255:0] fe_inv(logic [255:0] a);
		logic [255:0] acc;
		acc = 256'd1;
		for (int b = 255; b >= 0; b--) begin
			acc = fe_mul(acc, acc);
			if (PRIME_M2[b])
				acc = fe_mul(acc, a);
		end
		return acc;
	endfunction

	function automatic logic [255:0] coord_of(int sel);
		logic [255:0] v;
		v = {operand_words[sel*4+3], operand_words[sel*4+2],
			operand_words[sel*4+1], operand_words[sel*4]};
		if (v >= PRIME)
			v = v - PRIME;
		return v;
	endfunction

	task automatic predict_point(req_t req, logic err_known);
		logic [255:0] x1, y1, x2, y2, num, den, s, t, rx, ry;
		logic         fail;
		word_exp_t    e;
		x1 = coord_of(0);
		y1 = coord_of(1);
		x2 = coord_of(2);
		y2 = coord_of(3);
		if (req == REQ_ADD) begin
			num = fe_sub(y1, y2);
			den = fe_sub(x1, x2);
		end else begin
			t = fe_mul(x1, x1);
			num = fe_add(fe_add(t, t), t);
			den = fe_add(y1, y1);
		end
		fail = (den == 256'd0);
		rx = '0;
		ry = '0;
		if (!fail) begin
			s = fe_mul(num, fe_inv(den));
			rx = fe_sub(fe_sub(fe_mul(s, s), x1), (req == REQ_ADD) ? x2 : x1);
			ry = fe_sub(fe_mul(s, fe_sub(x1, rx)), y1);
		end
		for (int k = 0; k < 8; k++) begin
			e.coord = k[2];
			e.idx = k[1:0];
			e.word = (k < 4) ? rx[k*64 +: 64] : ry[(k-4)*64 +: 64];
			e.noinv = fail;
			e.last = (k == 7);
			if (err_known) begin
				e.word = '0;
				e.noinv = 1'b1;
			end
			result_q.push_back(e);
		end
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch on %s: got %h, expected %h", what, got, want);
		errors++;
	endtask

	task automatic push_req(req_t req, logic [1:0] sel, logic [1:0] idx, logic [63:0] val,
			logic err_known);
		point_req_t r;
		r.req = req;
		r.sel = sel;
		r.idx = idx;
		r.val = val;
		r.err_known = err_known;
		stim_q.push_back(r);
	endtask

	task automatic push_coord(logic [1:0] sel, logic [255:0] v);
		for (int w = 0; w < 4; w++)
			push_req(REQ_LOAD, sel, w[1:0], v[w*64 +: 64], 1'b0);
	endtask

	// directed table, then random transactions
	initial begin
		push_coord(2'd0, GX);
		push_coord(2'd1, GY);
		push_coord(2'd2, {256{1'b1}});
		push_coord(2'd3, 256'd0);
		push_req(REQ_NONE, 2'd3, 2'd3, {64{1'b1}}, 1'b0);
		push_req(REQ_DBL, 2'd0, 2'd0, '0, 1'b0);
		push_coord(2'd2, GX);
		push_req(REQ_ADD, 2'd0, 2'd0, '0, 1'b1);
		push_coord(2'd1, PRIME);
		push_req(REQ_DBL, 2'd0, 2'd0, '0, 1'b1);
		for (int i = 1; i <= 72; i++) begin
			logic [63:0] v;
			v = {$urandom, $urandom};
			case ($urandom_range(0, 7))
				0: v = '0;
				1: v = {64{1'b1}};
				default: ;
			endcase
			if (i % 24 == 0)
				push_req($urandom_range(0, 1) ? REQ_ADD : REQ_DBL, 2'($urandom_range(0, 3)),
					2'($urandom_range(0, 3)), v, 1'b0);
			else if ($urandom_range(0, 15) == 0)
				push_req(REQ_NONE, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), v,
					1'b0);
			else
				push_req(REQ_LOAD, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), v,
					1'b0);
		end
	end

	// sender: bursts with gaps
	initial begin
		int gap;
		int burst;
		point_req_t r;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		stim_done = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		burst = 0;
		while (stim_q.size() > 0) begin
			r = stim_q.pop_front();
			if (burst == 0) begin
				burst = $urandom_range(1, 8);
				gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst--;
			s_tvalid <= 1'b1;
			s_tdata <= r.val;
			s_tuser <= {2'b00, r.idx, r.sel, r.req};
			do @(posedge clk); while (!s_tready);
			if (r.req == REQ_ADD || r.req == REQ_DBL)
				predict_point(r.req, r.err_known);
			else if (r.req == REQ_LOAD) begin
				operand_words[{r.sel, r.idx}] = r.val;
				loads_done++;
			end
		end
		s_tvalid <= 1'b0;
		stim_done = 1'b1;
	end

	// receiver: random stall pattern, one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			held_once <= 1'b0;
			hold_left <= 0;
			stall_on <= 1'b0;
		end else begin
			if ($urandom_range(0, 19) == 0)
				stall_on <= ~stall_on;
			if (!held_once && m_tvalid) begin
				held_once <= 1'b1;
				hold_left <= 700;
				m_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= stall_on ? ($urandom_range(0, 2) == 0) : 1'b1;
			end
		end
	end

	// result checker and watchdog
	always @(posedge clk) begin
		word_exp_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (result_q.size() == 0) begin
				$display("result transaction with nothing expected: %h", m_tdata);
				errors++;
			end else begin
				e = result_q.pop_front();
				if (m_tuser[0] !== e.coord)
					report("coord_sel", 64'(m_tuser[0]), 64'(e.coord));
				if (m_tuser[2:1] !== e.idx)
					report("result_index", 64'(m_tuser[2:1]), 64'(e.idx));
				if (m_tdata !== e.word)
					report("result_word", m_tdata, e.word);
				if (m_tuser[3] !== e.noinv)
					report("no_inverse", 64'(m_tuser[3]), 64'(e.noinv));
				if (m_tlast !== e.last)
					report("last", 64'(m_tlast), 64'(e.last));
				words_checked++;
				if (e.last)
					runs_done++;
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		errors = 0;
		runs_done = 0;
		loads_done = 0;
		words_checked = 0;
		idle_cycles = 0;
		wait (stim_done === 1'b1);
		wait (result_q.size() == 0);
		repeat (200) @(posedge clk);
		$display("covered %0d operand loads and %0d point runs (add, double, no inverse)",
			loads_done, runs_done);
		$display("%0d result words compared, %0d mismatches", words_checked, errors);
		if (errors == 0 && result_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### sim.f
rtl/ecc_pad_pkg.sv
rtl/ecc_point_add_double_unit.sv
tb/sv/tb.sv
